// ===== rtl/core/mm64_pkg.sv =====
// mm64_pkg: shared types and constants for the modular multiply block.
// No dependencies.
package mm64_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int FIELD_BITS    = 64;

  typedef struct packed {
    logic [FIELD_BITS-1:0] operand_a;
    logic [FIELD_BITS-1:0] operand_b;
    logic [FIELD_BITS-1:0] modulus;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] remainder;
    logic [FIELD_BITS-1:0] quotient;
    logic                  error_flag;
  } out_word_t;

endpackage

// ===== rtl/core/mm64_div_stage.sv =====
// mm64_div_stage: one registered stage of restoring division, STEPS
// quotient bits per stage. Depends on mm64_pkg.
module mm64_div_stage
  import mm64_pkg::*;
#(
  parameter int WB    = WORD_BITS_DEF,
  parameter int STEPS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [WB-1:0] rem_in,
  input  logic [WB-1:0] num_in,   // low dividend bits, MSB next
  input  logic [WB-1:0] quo_in,
  input  logic [WB-1:0] den_in,
  input  logic          err_in,
  output logic          vld,
  output logic [WB-1:0] rem,
  output logic [WB-1:0] num,
  output logic [WB-1:0] quo,
  output logic [WB-1:0] den,
  output logic          err
);

  logic [WB-1:0] rem_next, num_next, quo_next;

  always_comb begin
    logic [WB:0] sh;
    rem_next = rem_in;
    num_next = num_in;
    quo_next = quo_in;
    for (int i = 0; i < STEPS; i++) begin
      sh       = {rem_next, num_next[WB-1]};
      num_next = {num_next[WB-2:0], 1'b0};
      if (sh >= {1'b0, den_in}) begin
        sh       = sh - {1'b0, den_in};
        quo_next = {quo_next[WB-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[WB-2:0], 1'b0};
      end
      rem_next = sh[WB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
    if (en) begin
      rem <= rem_next;
      num <= num_next;
      quo <= quo_next;
      den <= den_in;
      err <= err_in;
    end
  end

endmodule

// ===== rtl/core/modular_multiply_64.sv =====
// modular_multiply_64: pipelined (a*b) / m with quotient and remainder.
// Depends on mm64_pkg and mm64_div_stage.
//
// One word enters per cycle and one result leaves per cycle while the output
// is not stalled. The pipe is 4 multiply stages, then WORD_BITS/4 division
// stages, then the output register. The product is built from 32x32
// partial products (registered, then summed over two stages). Since the
// quotient must fit in WORD_BITS bits, the high half of the product must
// be below the modulus; that half then seeds the remainder and only the
// low WORD_BITS dividend bits run through the division chain, four bits
// per stage. A zero modulus or high half >= modulus sets error_flag with
// zero quotient and remainder. The whole pipe advances when the output
// register is empty or being taken, so a stall holds every word in place.
module modular_multiply_64
  import mm64_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int WB   = WORD_BITS;
  localparam int STP  = 4;
  localparam int NDIV = (WB + STP - 1) / STP;
  localparam int PADW = NDIV * STP;       // dividend padded to whole stages
  localparam int HW   = 32;

  // Pipe advances when the output slot frees up.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: masked operands, four 32x32 partial products
  logic          v1;
  logic [63:0]   p0, p1, p2, p3;
  logic [WB-1:0] d1;
  logic [63:0]   a_ext, b_ext;
  always_comb begin
    a_ext = 64'(in_data.operand_a[WB-1:0]);
    b_ext = 64'(in_data.operand_b[WB-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      p0 <= 64'(a_ext[HW-1:0])  * 64'(b_ext[HW-1:0]);
      p1 <= 64'(a_ext[HW-1:0])  * 64'(b_ext[63:HW]);
      p2 <= 64'(a_ext[63:HW])   * 64'(b_ext[HW-1:0]);
      p3 <= 64'(a_ext[63:HW])   * 64'(b_ext[63:HW]);
      d1 <= in_data.modulus[WB-1:0];
    end
  end

  // Stage 2: sum middle terms
  logic          v2;
  logic [64:0]   mid;
  logic [63:0]   p0_2, p3_2;
  logic [WB-1:0] d2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      mid  <= 65'(p1) + 65'(p2);
      p0_2 <= p0;
      p3_2 <= p3;
      d2   <= d1;
    end
  end

  // Stage 3: full product
  logic          v3;
  logic [127:0]  prod;
  logic [WB-1:0] d3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      prod <= 128'(p0_2) + {31'd0, mid, 32'd0} + {p3_2, 64'd0};
      d3   <= d2;
    end
  end

  // Stage 4: overflow check, seed the divider
  logic          v4;
  logic [WB-1:0] ph, pl, d4;
  logic          e4;
  always_comb begin
    ph = prod[2*WB-1:WB];
    pl = prod[WB-1:0];
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      e4 <= (d3 == '0) || (ph >= d3);
      d4 <= d3;
    end
  end
  logic [WB-1:0] ph4, pl4;
  always_ff @(posedge clk) begin
    if (en) begin
      ph4 <= ph;
      pl4 <= pl;
    end
  end

  // Division chain; low dividend left-aligned in PADW bits
  logic          dv  [NDIV+1];
  logic [WB-1:0] dr  [NDIV+1];
  logic [PADW-1:0] dn_pad;
  logic [WB-1:0] dn  [NDIV+1];
  logic [WB-1:0] dq  [NDIV+1];
  logic [WB-1:0] dd  [NDIV+1];
  logic          de  [NDIV+1];

  assign dn_pad = {pl4, {(PADW-WB){1'b0}}};
  assign dv[0]  = v4;
  assign dr[0]  = e4 ? '0 : ph4;
  assign dn[0]  = dn_pad[PADW-1 -: WB];
  assign dq[0]  = '0;
  assign dd[0]  = e4 ? {WB{1'b1}} : d4;
  assign de[0]  = e4;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    localparam int S = ((g + 1) * STP <= WB) ? STP : WB - g * STP;
    mm64_div_stage #(.WB(WB), .STEPS(S)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .vld_in(dv[g]), .rem_in(dr[g]), .num_in(dn[g]), .quo_in(dq[g]),
      .den_in(dd[g]), .err_in(de[g]),
      .vld(dv[g+1]), .rem(dr[g+1]), .num(dn[g+1]), .quo(dq[g+1]),
      .den(dd[g+1]), .err(de[g+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv[NDIV];
    if (en) begin
      out_data.error_flag <= de[NDIV];
      out_data.remainder  <= de[NDIV] ? '0 : 64'(dr[NDIV]);
      out_data.quotient   <= de[NDIV] ? '0 : 64'(dq[NDIV]);
    end
  end

endmodule

// ===== verif/modular_multiply_64_tb.sv =====
// modular_multiply_64_tb: self-checking bench for the pipelined modular multiply.
// Depends on mm64_pkg and modular_multiply_64; drives random and directed words
// through valid/ready and checks remainder, quotient and error flag per word.
`timescale 1ns / 100ps

module modular_multiply_64_tb;
  import mm64_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  localparam int LATENCY = 21;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;

  modular_multiply_64 #(.WORD_BITS(WB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // words waiting to be offered, and results predicted for accepted words
  in_word_t pending_words[$];
  out_word_t expected_results[$];
  int fail_count = 0;
  bit stim_done = 0;
  // sender pause request: hold off until every expected result has arrived
  bit drain_request = 0;
  // receiver long hold-off, in cycles, counted by the monitor
  int hold_cycles = 0;
  // one-cycle pulse from the driver that starts the long hold-off
  bit hold_request = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Exact (a*b) div/mod m at WB bits; error on zero modulus or wide quotient.
  function automatic out_word_t modmul_predict(in_word_t w);
    out_word_t r;
    logic [WB-1:0] a, b, m;
    logic [2*WB-1:0] prod, q, rm;
    a = w.operand_a[WB-1:0];
    b = w.operand_b[WB-1:0];
    m = w.modulus[WB-1:0];
    r = '0;
    r.error_flag = 1'b1;
    if (m != 0) begin
      prod = a * b;
      // quotient fits iff high half of product is below the modulus
      if (prod[2*WB-1:WB] < m) begin
        q = prod / m;
        rm = prod % m;
        r.quotient = q[WB-1:0];
        r.remainder = rm[WB-1:0];
        r.error_flag = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand shaping: biased toward edge values, small and full-range numbers.
  function automatic logic [63:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1;
      3: return 64'(1) << $urandom_range(0, 63);
      4: return 64'($urandom_range(0, 255));
      5: return rand64() >> $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  function automatic in_word_t make_word(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    in_word_t w;
    w.operand_a = a;
    w.operand_b = b;
    w.modulus = m;
    return w;
  endfunction

  // Random word: mostly a valid (non-overflowing) product, some error cases.
  function automatic in_word_t random_word();
    logic [63:0] a, b, m;
    a = rand_field();
    b = rand_field();
    m = rand_field();
    if ($urandom_range(0, 9) < 7) begin
      logic [127:0] p;
      p = a * b;
      // raise the modulus above the product's high half so the quotient fits
      if (p[127:64] >= m) begin
        if (p[127:64] == '1) m = '1 - 64'($urandom_range(0, 1));
        else m = p[127:64] + 1 + (rand64() % (~p[127:64]));
      end
    end
    return make_word(a, b, m);
  endfunction

  // Stimulus: directed corners, then random words.
  initial begin
    pending_words.push_back(make_word(0, 0, 0));
    pending_words.push_back(make_word('1, '1, 0));
    pending_words.push_back(make_word('1, '1, '1));
    pending_words.push_back(make_word('1, '1, '1 - 1));
    pending_words.push_back(make_word(0, '1, 1));
    pending_words.push_back(make_word('1, 1, 1));
    pending_words.push_back(make_word(1, 1, '1));
    pending_words.push_back(make_word('1, 2, '1));
    pending_words.push_back(make_word(64'h8000_0000_0000_0000, 2, 1));
    pending_words.push_back(make_word(64'h8000_0000_0000_0000, 2, 2));
    pending_words.push_back(make_word(64'h1_0000_0000, 64'h1_0000_0000, 1));
    pending_words.push_back(make_word(64'h1_0000_0000, 64'h1_0000_0000, 2));
    pending_words.push_back(make_word(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF));
    pending_words.push_back(make_word(12345, 67890, 7));
    pending_words.push_back(make_word(64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF,
                                      64'hFFFF_FFFF_FFFF_FFC5));
    pending_words.push_back(make_word('1, '1, 64'h8000_0000_0000_0000));
    pending_words.push_back(make_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                      64'hAAAA_AAAA_AAAA_AAAB));
    for (int i = 0; i < 1300; i++) pending_words.push_back(random_word());
    stim_done = 1;
  end

  // Driver: offers words from the queue with random gaps; payload held until taken.
  int gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap <= 0;
      hold_request <= 1'b0;
    end else begin
      automatic bit taken = in_valid && in_ready;
      automatic bit can_offer;
      // one long receiver hold-off while sending continues
      hold_request <= taken && (sent == 300);
      if (taken) begin
        expected_results.push_back(modmul_predict(in_data));
        sent <= sent + 1;
        // one sender pause: wait for the pipe to drain after word 600
        if (sent == 600) drain_request <= 1'b1;
      end
      if (!in_valid || taken) begin
        can_offer = (gap == 0) && pending_words.size() > 0 &&
                    !(drain_request || (taken && sent == 600));
        if (can_offer) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
          if ($urandom_range(0, 3) == 0)
            gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
          if (gap > 0) gap <= gap - 1;
        end
      end
      if (drain_request && expected_results.size() == 0 && !taken)
        drain_request <= 1'b0;
    end
  end

  // Monitor: random backpressure, plus one long hold-off; checks each word.
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result rem=%h quo=%h err=%b", $time,
                   out_data.remainder, out_data.quotient, out_data.error_flag);
          fail_count++;
        end else begin
          automatic out_word_t e = expected_results.pop_front();
          if (out_data.remainder !== e.remainder) begin
            $display("%0t: remainder expected %h actual %h", $time,
                     e.remainder, out_data.remainder);
            fail_count++;
          end
          if (out_data.quotient !== e.quotient) begin
            $display("%0t: quotient expected %h actual %h", $time,
                     e.quotient, out_data.quotient);
            fail_count++;
          end
          if (out_data.error_flag !== e.error_flag) begin
            $display("%0t: error_flag expected %b actual %b", $time,
                     e.error_flag, out_data.error_flag);
            fail_count++;
          end
        end
      end
      if (hold_request && hold_cycles == 0) begin
        hold_cycles <= 120;
        out_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Reset, then wait for all words sent and all results seen.
  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (LATENCY * 4) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("** modular_multiply_64: PASSED **");
    else
      $display("** modular_multiply_64: FAILED **");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10000000;
    $display("** modular_multiply_64: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mm64_pkg.sv
rtl/core/mm64_div_stage.sv
rtl/core/modular_multiply_64.sv
verif/modular_multiply_64_tb.sv
